FILE: hdl/chained_byte_cipher_core_assert.svh
// assertion macros for the chained byte cipher core
// depends on nothing; included by the top level that uses the macros
`ifndef CHAINED_BYTE_CIPHER_CORE_ASSERT_SVH
`define CHAINED_BYTE_CIPHER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cbc_pkg.sv
// shared constants, types and datapath functions for the chained byte cipher
// depends on nothing; used by the channel interfaces and the top level
package cbc_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned KeyW  = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [DataW-1:0] ChainIv         = 8'hCB;
  localparam logic [KeyW-1:0]  PartialKeyReset = 4'd1;
  localparam logic             DecryptReset    = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPartialKey  = 1'b0,
    CfgDecryptMode = 1'b1
  } cfg_idx_e;

  // high nibble is the partial key, low bits are inverted copies of high bits
  function automatic logic [DataW-1:0] start_key(input logic [KeyW-1:0] pk);
    start_key = {pk, ~pk[0], ~pk[3], ~pk[2], ~pk[1]};
  endfunction

  // divisibility by 3: base-4 digit sum keeps the residue mod 3
  function automatic logic div_by_3(input logic [DataW-1:0] v);
    logic [3:0] s;
    s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
    div_by_3 = (s == 4'd0) || (s == 4'd3) || (s == 4'd6) || (s == 4'd9) ||
               (s == 4'd12);
  endfunction

  // rotate left twice, once more when the result is divisible by 3
  function automatic logic [DataW-1:0] advance_key(input logic [DataW-1:0] k);
    logic [DataW-1:0] r2;
    r2 = {k[5:0], k[7:6]};
    advance_key = div_by_3(r2) ? {r2[6:0], r2[7]} : r2;
  endfunction

  // bit i xors chain bit (7 - i + r) mod 8, r the number of set key bits 0..i
  function automatic logic [DataW-1:0] mix_byte(input logic [DataW-1:0] data,
                                                input logic [DataW-1:0] key,
                                                input logic [DataW-1:0] chain);
    logic [DataW-1:0] res;
    logic [2:0]       rot;
    logic [2:0]       idx;
    res = '0;
    rot = '0;
    for (int i = 0; i < DataW; i++) begin
      rot    = rot + {2'b00, key[i]};
      idx    = 3'(DataW - 1 - i) + rot;
      res[i] = data[i] ^ chain[idx];
    end
    mix_byte = res;
  endfunction

endpackage

FILE: hdl/cbc_if.sv
// valid/ready channel interfaces: input bytes, result bytes, config writes
// depends on cbc_pkg for widths
interface cbc_in_if import cbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_in;
  logic             start_of_message;
  modport source (output valid, data_in, start_of_message, input ready);
  modport sink   (input valid, data_in, start_of_message, output ready);
endinterface

interface cbc_out_if import cbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_out;
  modport source (output valid, data_out, input ready);
  modport sink   (input valid, data_out, output ready);
endinterface

interface cbc_cfg_if import cbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [KeyW-1:0]    wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: hdl/chained_byte_cipher_core.sv
// chained byte cipher core: top level, one byte in and one byte out
// depends on cbc_pkg, cbc_if.sv and chained_byte_cipher_core_assert.svh
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+-----------
//  cfg_i   | in  | index (1b), wdata (4b)           | valid/ready
//  in_i    | in  | data_in (8b), start_of_message   | valid/ready
//  out_o   | out | data_out (8b)                    | valid/ready
//
// a byte is registered in the input stage, then in the result stage, before it is offered on out_o
// one byte per cycle sustained while out_o is ready; the key/chain state update in the result stage
// closes the only datapath loop: key advance with its divisible-by-3 check, a chain bit select and an xor per bit
// stalls on out_o back up through the input register into in_i.ready
// reset clears valids, loads partial_key 1, encrypt mode, its start key and iv
// cfg_i is always ready; decrypt mode applies to the next processed byte,
// a new partial_key only at the next start of message
`include "chained_byte_cipher_core_assert.svh"

module chained_byte_cipher_core import cbc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  cbc_cfg_if.sink   cfg_i,
  cbc_in_if.sink    in_i,
  cbc_out_if.source out_o
);

  // configuration registers
  logic [KeyW-1:0]  partial_key_q;
  logic             decrypt_q;

  // input register stage
  logic             in_valid_q;
  logic [DataW-1:0] in_data_q;
  logic             in_sop_q;

  // cipher state, updated as each byte leaves the input stage
  logic [DataW-1:0] key_q,   key_d;
  logic [DataW-1:0] chain_q, chain_d;

  // result register stage
  logic             out_valid_q;
  logic [DataW-1:0] out_data_q, out_data_d;

  logic             advance;
  logic [DataW-1:0] chain_cur;

  // result stage frees up when empty or when its byte is taken this cycle
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;

  // start of message restarts key and chain before this byte
  always_comb begin
    key_d      = advance_key(in_sop_q ? start_key(partial_key_q) : key_q);
    chain_cur  = in_sop_q ? ChainIv : chain_q;
    out_data_d = mix_byte(in_data_q, key_d, chain_cur);
    // ciphertext feeds the chain: output when encrypting, input when decrypting
    chain_d    = decrypt_q ? in_data_q : out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_key_q <= PartialKeyReset;
      decrypt_q     <= DecryptReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgPartialKey:  partial_key_q <= cfg_i.wdata;
        CfgDecryptMode: decrypt_q     <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      key_q       <= start_key(PartialKeyReset);
      chain_q     <= ChainIv;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        key_q       <= key_d;
        chain_q     <= chain_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data_in;
      in_sop_q  <= in_i.start_of_message;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // a byte in the input stage that cannot move on stays there
  `CBC_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !advance, in_valid_q, "input stage dropped a byte")
  // every byte that moves on shows up as a result
  `CBC_ASSERT_NEXT(a_out_fill, clk_i, rst_ni, advance, out_valid_q, "result stage missed a byte")
  // in decrypt mode the chain carries the received byte
  `CBC_ASSERT_NEXT(a_dec_chain, clk_i, rst_ni, advance && decrypt_q, chain_q == $past(in_data_q), "decrypt chain not from input")

endmodule
